FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the paged allocator.
// Depends on nothing; the checks vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked on every rising clock edge outside reset.
`define PAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Same check, also active while reset is asserted.
`define PAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PAT_ASSERT(lbl, prop, msg)
`define PAT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/pat_pkg.sv
// Package of the paged allocator: geometry constants, request codes and states.
// Used by paged_allocator_with_translation; depends on nothing.
package pat_pkg;

  localparam int unsigned OFFSET_BITS    = 8;
  localparam int unsigned PAGE_BITS      = 4;
  localparam int unsigned SEG_BITS       = 4;
  localparam int unsigned NUM_PHYS_PAGES = 64;
  localparam int unsigned NUM_PROCS      = 8;

  localparam int unsigned VA_W       = OFFSET_BITS + PAGE_BITS + SEG_BITS;
  localparam int unsigned VPN_W      = PAGE_BITS + SEG_BITS;
  localparam int unsigned PROC_W     = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int unsigned PPN_W      = $clog2(NUM_PHYS_PAGES);
  localparam int unsigned MAP_AW     = PROC_W + VPN_W;
  localparam int unsigned RAM_AW     = PPN_W + OFFSET_BITS;
  localparam int unsigned BRK_W      = VA_W + 1;
  localparam int unsigned PAGES_W    = VA_W - OFFSET_BITS + 1;
  localparam int unsigned FREE_W     = $clog2(NUM_PHYS_PAGES + 1);
  localparam int unsigned PAGE_BYTES = 1 << OFFSET_BITS;
  localparam int unsigned RAM_BYTES  = NUM_PHYS_PAGES << OFFSET_BITS;
  localparam int unsigned VSPACE     = 1 << VA_W;
  localparam int unsigned BRK_LIMIT  = (RAM_BYTES < VSPACE) ? RAM_BYTES : VSPACE;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_READ,
    ST_WALK,
    ST_RESP
  } state_e;

endpackage

FILE: rtl/paged_allocator_with_translation.sv
// Paged allocator with per-process address translation: the whole block.
// Depends on pat_pkg and assert_macros.svh.
//
// Usage: one request word enters on the input channel (func_i, pid_i, size_i,
// address_i, write_data_i) and one result word leaves on the output channel
// (status_o, read_data_o, alloc_address_o), both with valid/ready handshakes.
// Requests are worked one at a time. A read passes the map memory read, the
// RAM read and the result stage on its way to the output register, a write
// the map memory read and the result stage, a rejected request the result
// stage only. An allocation walks the page ownership flags one page per
// cycle from page 0 until it has claimed every page it asked for. The block
// is ready for the next request once the result enters the output register.
// The map memory has one read and one write port, the byte RAM one port shared
// by reads and writes; both have registered read data.
// Mapped virtual pages of a process are exactly those from page 1 up to its
// break, so the map memory needs no clearing. After reset the byte RAM is
// cleared one byte per cycle, every byte of it, and no request is taken meanwhile.
// A finished result waits in an output register; while the receiver stalls
// the block holds the next result and takes no new request until it is taken.
`include "assert_macros.svh"

module paged_allocator_with_translation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [3:0]  pid_i,
  input  logic [15:0] size_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [7:0]  read_data_o,
  output logic [15:0] alloc_address_o
);

  pat_pkg::state_e state_q, state_d;

  // Memories.
  logic [pat_pkg::PPN_W-1:0] map_mem [2**pat_pkg::MAP_AW];
  logic [7:0]                ram_mem [2**pat_pkg::RAM_AW];
  logic [pat_pkg::PPN_W-1:0] map_rdata_q;
  logic [7:0]                ram_rdata_q;
  logic                      map_we;
  logic [pat_pkg::MAP_AW-1:0] map_waddr, map_raddr;
  logic [pat_pkg::PPN_W-1:0] map_wdata;
  logic                      ram_we;
  logic [pat_pkg::RAM_AW-1:0] ram_addr;
  logic [7:0]                ram_wdata;

  // Control state.
  logic [pat_pkg::BRK_W-1:0]    brk_q [pat_pkg::NUM_PROCS];
  logic [pat_pkg::NUM_PHYS_PAGES-1:0] page_used_q;
  logic [pat_pkg::FREE_W-1:0]   free_cnt_q;
  logic [pat_pkg::RAM_AW-1:0]   clr_q;

  // Request working registers.
  logic [1:0]                   func_q;
  logic [pat_pkg::PROC_W-1:0]   proc_q;
  logic [pat_pkg::OFFSET_BITS-1:0] offs_q;
  logic [7:0]                   wdata_q;
  logic [pat_pkg::PAGES_W-1:0]  pages_q, used_q;
  logic [pat_pkg::VPN_W-1:0]    vpn_q;
  logic [pat_pkg::PPN_W-1:0]    idx_q;

  // Result stage and output register.
  logic        res_status_q, res_status_d;
  logic [7:0]  res_rdata_q, res_rdata_d;
  logic [15:0] res_addr_q, res_addr_d;
  logic        out_valid_q;
  logic        out_load;

  // Request decode.
  logic                          accept;
  logic                          pid_ok, func_ok, mapped, alloc_ok;
  logic [pat_pkg::PROC_W-1:0]    proc_in;
  logic [3:0]                    pid_m1;
  logic [pat_pkg::BRK_W-1:0]     brk_cur, brk_new;
  logic [pat_pkg::VPN_W-1:0]     vpn_in;
  logic [16:0]                   size_rnd;
  logic [pat_pkg::PAGES_W-1:0]   pages_in;
  logic                          claim, walk_last;

  assign accept  = in_valid_i && in_ready_o;
  assign pid_m1  = pid_i - 4'd1;
  assign proc_in = pid_m1[pat_pkg::PROC_W-1:0];
  assign pid_ok  = (pid_i != 4'd0) && (pid_i <= 4'(pat_pkg::NUM_PROCS));
  assign func_ok = (func_i == pat_pkg::FUNC_ALLOC) || (func_i == pat_pkg::FUNC_READ) ||
                   (func_i == pat_pkg::FUNC_WRITE);
  assign brk_cur = brk_q[proc_in];
  assign vpn_in  = address_i[pat_pkg::VA_W-1:pat_pkg::OFFSET_BITS];
  // The break always sits on a page boundary, so mapped pages are 1 .. break-1.
  assign mapped  = (vpn_in != '0) &&
                   ({1'b0, vpn_in} < brk_cur[pat_pkg::BRK_W-1:pat_pkg::OFFSET_BITS]);

  assign size_rnd = {1'b0, size_i} + 17'(pat_pkg::PAGE_BYTES - 1);
  always_comb begin
    pages_in = pat_pkg::PAGES_W'(size_rnd >> pat_pkg::OFFSET_BITS);
    if (pages_in == '0) begin
      pages_in = pat_pkg::PAGES_W'(1);
    end
  end
  assign brk_new  = brk_cur + (pat_pkg::BRK_W'(pages_in) << pat_pkg::OFFSET_BITS);
  assign alloc_ok = ({2'b0, free_cnt_q} >= pat_pkg::PAGES_W'(pages_in)) &&
                    (brk_new <= pat_pkg::BRK_W'(pat_pkg::BRK_LIMIT));

  assign claim     = (state_q == pat_pkg::ST_WALK) && !page_used_q[idx_q];
  assign walk_last = claim && ((used_q + 1'b1) == pages_q);
  assign out_load  = (state_q == pat_pkg::ST_RESP) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pat_pkg::ST_CLEAR: begin
        if (clr_q == '1) state_d = pat_pkg::ST_IDLE;
      end
      pat_pkg::ST_IDLE: begin
        if (accept) begin
          if (!pid_ok || !func_ok) begin
            state_d = pat_pkg::ST_RESP;
          end else if (func_i == pat_pkg::FUNC_ALLOC) begin
            state_d = alloc_ok ? pat_pkg::ST_WALK : pat_pkg::ST_RESP;
          end else begin
            state_d = mapped ? pat_pkg::ST_LOOK : pat_pkg::ST_RESP;
          end
        end
      end
      pat_pkg::ST_LOOK: begin
        state_d = (func_q == pat_pkg::FUNC_READ) ? pat_pkg::ST_READ : pat_pkg::ST_RESP;
      end
      pat_pkg::ST_READ: state_d = pat_pkg::ST_RESP;
      pat_pkg::ST_WALK: begin
        if (walk_last) state_d = pat_pkg::ST_RESP;
      end
      pat_pkg::ST_RESP: begin
        if (out_load) state_d = pat_pkg::ST_IDLE;
      end
      default: state_d = pat_pkg::ST_IDLE;
    endcase
  end

  // Memory ports and result values.
  always_comb begin
    map_raddr    = {proc_in, vpn_in};
    map_we       = claim;
    map_waddr    = {proc_q, vpn_q + used_q[pat_pkg::VPN_W-1:0]};
    map_wdata    = idx_q;
    ram_we       = 1'b0;
    ram_addr     = {map_rdata_q, offs_q};
    ram_wdata    = wdata_q;
    res_status_d = res_status_q;
    res_rdata_d  = res_rdata_q;
    res_addr_d   = res_addr_q;
    case (state_q)
      pat_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = 8'd0;
      end
      pat_pkg::ST_IDLE: begin
        res_status_d = 1'b1;
        res_rdata_d  = 8'd0;
        res_addr_d   = 16'd0;
        if (pid_ok && (func_i == pat_pkg::FUNC_ALLOC) && alloc_ok) begin
          res_status_d = 1'b0;
          res_addr_d   = brk_cur[15:0];
        end
      end
      pat_pkg::ST_LOOK: begin
        if (func_q == pat_pkg::FUNC_WRITE) begin
          ram_we       = 1'b1;
          res_status_d = 1'b0;
        end
      end
      pat_pkg::ST_READ: begin
        res_status_d = 1'b0;
        res_rdata_d  = ram_rdata_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_rdata_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) ram_mem[ram_addr] <= ram_wdata;
    ram_rdata_q <= ram_mem[ram_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pat_pkg::ST_CLEAR;
      clr_q       <= '0;
      page_used_q <= '0;
      free_cnt_q  <= pat_pkg::FREE_W'(pat_pkg::NUM_PHYS_PAGES);
      out_valid_q <= 1'b0;
      used_q      <= '0;
      idx_q       <= '0;
      for (int p = 0; p < pat_pkg::NUM_PROCS; p++) begin
        brk_q[p] <= pat_pkg::BRK_W'(pat_pkg::PAGE_BYTES);
      end
    end else begin
      state_q <= state_d;
      if (state_q == pat_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (accept) begin
        used_q <= '0;
        idx_q  <= '0;
        if (pid_ok && (func_i == pat_pkg::FUNC_ALLOC) && alloc_ok) begin
          brk_q[proc_in] <= brk_new;
        end
      end
      if (state_q == pat_pkg::ST_WALK) begin
        idx_q <= idx_q + 1'b1;
        if (claim) begin
          page_used_q[idx_q] <= 1'b1;
          free_cnt_q         <= free_cnt_q - 1'b1;
          used_q             <= used_q + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_i;
      proc_q  <= proc_in;
      offs_q  <= address_i[pat_pkg::OFFSET_BITS-1:0];
      wdata_q <= write_data_i;
      pages_q <= pages_in;
      vpn_q   <= brk_cur[pat_pkg::OFFSET_BITS +: pat_pkg::VPN_W];
    end
    res_status_q <= res_status_d;
    res_rdata_q  <= res_rdata_d;
    res_addr_q   <= res_addr_d;
    if (out_load) begin
      status_o        <= res_status_q;
      read_data_o     <= res_rdata_q;
      alloc_address_o <= res_addr_q;
    end
  end

  assign in_ready_o  = (state_q == pat_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  `PAT_ASSERT(a_free_count, free_cnt_q == pat_pkg::FREE_W'(pat_pkg::NUM_PHYS_PAGES - $countones(page_used_q)), "free page count out of step with ownership flags")
  `PAT_ASSERT(a_walk_bound, (state_q == pat_pkg::ST_WALK) |-> (used_q < pages_q), "page walk claimed more pages than requested")
  `PAT_ASSERT(a_busy_after_accept, accept |=> !in_ready_o, "request taken while a request is in work")
  `PAT_ASSERT_ALWAYS(a_reset_clear, !rst_ni |=> (state_q == pat_pkg::ST_CLEAR) || rst_ni, "reset did not start the RAM clear")

endmodule
